// File: design/tks_pkg.sv
// Shared types and constants for the top-k smallest select unit.
`default_nettype none

package tks_pkg;

    localparam int HEIGHT_W = 12;
    localparam int NAME_W   = 64;
    localparam int INDEX_W  = 7;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] TOP_COUNT_RESET = 5'd10;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [NAME_W-1:0]   name_key;
        logic                last_item;
    } in_word_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] out_height;
        logic [NAME_W-1:0]   out_name_key;
        logic [INDEX_W-1:0]  arrival_index;
        logic                last_result;
    } out_word_t;

    typedef struct packed {
        logic                valid;
        logic [HEIGHT_W-1:0] height;
        logic [NAME_W-1:0]   name_key;
        logic [INDEX_W-1:0]  index;
    } cell_entry_t;

    // one command per cycle to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/top_k_smallest_select_unit.sv
// Top level: collects a record set in a sorted cell chain and emits the k smallest.
`default_nettype none

// Records enter one per cycle and each one is placed into a chain of MAX_SELECT sorted
// cells in the same cycle: every cell compares the record with its own entry (height,
// then name key, older first on a tie) and either keeps, takes the record, or takes its
// neighbor's entry. Records past MAX_RECORDS in a set are dropped but a last_item mark on
// them still ends the set. After the record marked last_item, the input stalls while the
// chain shifts its head out through the output register, one word per cycle when the
// output is not stalled: n words leave, n = min(top_count, MAX_SELECT, records held),
// and the chain is then cleared, empty for the next set. top_count resets to 10.
module top_k_smallest_select_unit
#(
    parameter int MAX_RECORDS = 128,
    parameter int MAX_SELECT  = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire tks_pkg::in_word_t         in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output tks_pkg::out_word_t             out_data,
    input  wire logic                      cfg_we,
    input  wire logic [tks_pkg::CFG_W-1:0] cfg_data
);

    localparam int ARR_W  = $clog2(MAX_RECORDS + 1);
    localparam int FILL_W = $clog2(MAX_SELECT + 1);

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } state_t;

    state_t                     state_reg;
    logic [tks_pkg::CFG_W-1:0]  top_count_reg;
    logic [ARR_W-1:0]           arrivals_reg;
    logic [FILL_W-1:0]          fill_reg;
    logic [FILL_W-1:0]          remain_reg;
    logic                       out_valid_reg;
    tks_pkg::out_word_t         out_reg;

    tks_pkg::cell_entry_t       entry [MAX_SELECT];
    logic                       after [MAX_SELECT];
    logic [MAX_SELECT-1:0]      valid_vec;
    tks_pkg::cell_entry_t       rec;
    tks_pkg::cell_ctrl_t        ctrl;

    logic                       accept;
    logic                       take;
    logic                       load_out;
    logic [31:0]                arr_ext;
    logic [31:0]                want;
    logic [31:0]                fill_after;
    logic [31:0]                emit_count;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_COLLECT);
    assign take     = accept && (32'(arrivals_reg) < MAX_RECORDS);
    assign arr_ext  = 32'(arrivals_reg);

    assign rec.valid    = 1'b1;
    assign rec.height   = in_data.height;
    assign rec.name_key = in_data.name_key;
    assign rec.index    = arr_ext[tks_pkg::INDEX_W-1:0];

    assign load_out = (state_reg == ST_EMIT) && (remain_reg != '0)
                   && (!out_valid_reg || !out_stall);

    assign ctrl.insert = take;
    assign ctrl.shift  = load_out;
    assign ctrl.clear  = (state_reg == ST_EMIT) && (remain_reg == '0);

    // count of words to emit once the last record is in
    always_comb
    begin
        want = (32'(top_count_reg) > MAX_SELECT) ? MAX_SELECT : 32'(top_count_reg);
        fill_after = 32'(fill_reg);
        if (take && (32'(fill_reg) < MAX_SELECT))
        begin
            fill_after = 32'(fill_reg) + 32'd1;
        end
        emit_count = (want < fill_after) ? want : fill_after;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SELECT; gi++)
        begin : g_cell
            tks_pkg::cell_entry_t prev_e;
            logic                 prev_a;
            tks_pkg::cell_entry_t next_e;

            if (gi == 0)
            begin : g_head
                assign prev_e = rec;
                assign prev_a = 1'b0;
            end
            else
            begin : g_body
                assign prev_e = entry[gi-1];
                assign prev_a = after[gi-1];
            end

            if (gi == MAX_SELECT - 1)
            begin : g_tail
                assign next_e = '0;
            end
            else
            begin : g_link
                assign next_e = entry[gi+1];
            end

            tks_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .rec        (rec),
                .prev_entry (prev_e),
                .prev_after (prev_a),
                .next_entry (next_e),
                .entry      (entry[gi]),
                .after      (after[gi])
            );

            assign valid_vec[gi] = entry[gi].valid;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            top_count_reg <= tks_pkg::TOP_COUNT_RESET;
            arrivals_reg  <= '0;
            fill_reg      <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                top_count_reg <= cfg_data;
            end

            if (out_valid_reg && !out_stall && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end

            case (state_reg)
                ST_COLLECT:
                begin
                    if (take)
                    begin
                        arrivals_reg <= arrivals_reg + ARR_W'(1);
                        fill_reg     <= FILL_W'(fill_after);
                    end
                    if (accept && in_data.last_item)
                    begin
                        remain_reg <= FILL_W'(emit_count);
                        state_reg  <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (remain_reg == '0)
                    begin
                        // drop the rest of the set
                        arrivals_reg <= '0;
                        fill_reg     <= '0;
                        state_reg    <= ST_COLLECT;
                    end
                    else if (load_out)
                    begin
                        remain_reg <= remain_reg - FILL_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_COLLECT;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.out_height    <= entry[0].height;
            out_reg.out_name_key  <= entry[0].name_key;
            out_reg.arrival_index <= entry[0].index;
            out_reg.last_result   <= (remain_reg == FILL_W'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // held cells form a prefix of the chain; while collecting, the fill register counts them
    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COLLECT) |-> ($countones(valid_vec) == 32'(fill_reg)))
        else $error("fill count disagrees with held cells");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= MAX_SELECT)
        else $error("fill count beyond chain length");

    a_arr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(arrivals_reg) <= MAX_RECORDS)
        else $error("arrival count beyond set capacity");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && (remain_reg != '0)) |-> valid_vec[0])
        else $error("emitting from an empty chain head");

    a_empty_after_set: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && (remain_reg == '0)) |=> (valid_vec == '0))
        else $error("chain not cleared at end of set");

endmodule

`default_nettype wire

// File: design/tks_cell.sv
// One cell of the sorted chain: holds a record, inserts in place or shifts toward the head.
`default_nettype none

module tks_cell
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tks_pkg::cell_ctrl_t  ctrl,
    input  wire tks_pkg::cell_entry_t rec,
    input  wire tks_pkg::cell_entry_t prev_entry,
    input  wire logic                 prev_after,
    input  wire tks_pkg::cell_entry_t next_entry,
    output tks_pkg::cell_entry_t      entry,
    output logic                      after
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [tks_pkg::HEIGHT_W-1:0]     height_reg;
    logic [tks_pkg::HEIGHT_W-1:0]     height_next;
    logic [tks_pkg::NAME_W-1:0]       name_reg;
    logic [tks_pkg::NAME_W-1:0]       name_next;
    logic [tks_pkg::INDEX_W-1:0]      index_reg;
    logic [tks_pkg::INDEX_W-1:0]      index_next;
    tks_pkg::cell_entry_t             load_entry;
    logic                             load;

    // an empty cell sorts after everything; ties keep the older record first
    assign after = !valid_reg
                || (height_reg > rec.height)
                || ((height_reg == rec.height) && (name_reg > rec.name_key));

    always_comb
    begin
        load       = 1'b0;
        load_entry = next_entry;
        if (ctrl.insert && after)
        begin
            load       = 1'b1;
            load_entry = prev_after ? prev_entry : rec;
        end
        else if (ctrl.shift)
        begin
            load       = 1'b1;
            load_entry = next_entry;
        end

        valid_next  = valid_reg;
        height_next = height_reg;
        name_next   = name_reg;
        index_next  = index_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (load)
        begin
            valid_next  = load_entry.valid;
            height_next = load_entry.height;
            name_next   = load_entry.name_key;
            index_next  = load_entry.index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        height_reg <= height_next;
        name_reg   <= name_next;
        index_reg  <= index_next;
    end

    assign entry.valid    = valid_reg;
    assign entry.height   = height_reg;
    assign entry.name_key = name_reg;
    assign entry.index    = index_reg;

endmodule

`default_nettype wire

// File: tb/top_k_smallest_select_unit_tb.sv
// Self-checking testbench for the top-k smallest select unit: directed sets, then random sets.
`timescale 1ns / 100ps

module top_k_smallest_select_unit_tb;

    localparam int MAX_REC       = 128;
    localparam int MAX_SEL       = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [tks_pkg::NAME_W-1:0] NAME_ALICE = 64'h414C4943_45000000;
    localparam logic [tks_pkg::NAME_W-1:0] NAME_ALICD = 64'h414C4943_44FFFFFF;
    localparam logic [tks_pkg::NAME_W-1:0] NAME_BOB   = 64'h424F4200_00000000;
    localparam logic [tks_pkg::NAME_W-1:0] NAME_CAROL = 64'h4341524F_4C000000;

    typedef struct packed {
        tks_pkg::in_word_t  word;
        bit                 typed;
        tks_pkg::out_word_t want;
    } probe_row_t;

    typedef struct packed {
        logic [tks_pkg::CFG_W-1:0] top;
        int                        gap_pct;
        int                        stall_pct;
        int                        budget;
        bit                        flood;
    } phase_t;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    tks_pkg::in_word_t         in_data   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    tks_pkg::out_word_t        out_data;
    logic                      cfg_we    = 1'b0;
    logic [tks_pkg::CFG_W-1:0] cfg_data  = '0;

    int gap_pct        = 0;
    int stall_pct      = 0;
    int mismatch_count = 0;

    // predictor state: sorted cells of the current set
    logic [tks_pkg::HEIGHT_W-1:0] held_height [MAX_SEL];
    logic [tks_pkg::NAME_W-1:0]   held_name   [MAX_SEL];
    logic [tks_pkg::INDEX_W-1:0]  held_index  [MAX_SEL];
    int                           held_count   = 0;
    int                           set_arrivals = 0;
    logic [tks_pkg::CFG_W-1:0]    sel_count    = tks_pkg::TOP_COUNT_RESET;

    tks_pkg::out_word_t ranked_q     [$];
    tks_pkg::out_word_t owed_records [$];
    tks_pkg::out_word_t head_rank;

    // one set ends per row with last_item set; typed rows carry their one result
    probe_row_t probe_rows [23] = '{
        '{{12'd0, 64'd0, 1'b1}, 1'b1, {12'd0, 64'd0, 7'd0, 1'b1}},
        '{{12'd4095, {64{1'b1}}, 1'b1}, 1'b1, {12'd4095, {64{1'b1}}, 7'd0, 1'b1}},
        '{{12'd170, NAME_ALICE, 1'b0}, 1'b0, '0},
        '{{12'd170, NAME_ALICE, 1'b0}, 1'b0, '0},
        '{{12'd170, NAME_BOB, 1'b0}, 1'b0, '0},
        '{{12'd169, NAME_CAROL, 1'b0}, 1'b0, '0},
        '{{12'd4095, 64'd0, 1'b0}, 1'b0, '0},
        '{{12'd0, {64{1'b1}}, 1'b0}, 1'b0, '0},
        '{{12'd170, NAME_ALICD, 1'b1}, 1'b0, '0},
        '{{12'd3000, NAME_BOB, 1'b0}, 1'b0, '0},
        '{{12'd10, NAME_CAROL, 1'b0}, 1'b0, '0},
        '{{12'd2500, 64'h0123_4567_89AB_CDEF, 1'b0}, 1'b0, '0},
        '{{12'd10, NAME_ALICE, 1'b0}, 1'b0, '0},
        '{{12'd4095, 64'hFEDC_BA98_7654_3210, 1'b0}, 1'b0, '0},
        '{{12'd1, NAME_BOB, 1'b0}, 1'b0, '0},
        '{{12'd2000, 64'h8000_0000_0000_0000, 1'b0}, 1'b0, '0},
        '{{12'd10, NAME_CAROL, 1'b0}, 1'b0, '0},
        '{{12'd700, 64'h0000_0000_0000_0001, 1'b0}, 1'b0, '0},
        '{{12'd0, NAME_ALICE, 1'b0}, 1'b0, '0},
        '{{12'd3333, 64'h5555_AAAA_5555_AAAA, 1'b0}, 1'b0, '0},
        '{{12'd64, 64'hAAAA_5555_AAAA_5555, 1'b0}, 1'b0, '0},
        '{{12'd128, NAME_ALICD, 1'b0}, 1'b0, '0},
        '{{12'd1, NAME_BOB, 1'b1}, 1'b0, '0}
    };

    phase_t phase_plan [6] = '{
        '{5'd1,  0,  0,  20,  1'b0},
        '{5'd16, 49, 0,  30,  1'b0},
        '{5'd0,  0,  49, 15,  1'b0},
        '{5'd31, 18, 18, 132, 1'b1},
        '{5'd17, 0,  49, 20,  1'b0},
        '{5'd5,  18, 18, 25,  1'b0}
    };

    top_k_smallest_select_unit #(
        .MAX_RECORDS (MAX_REC),
        .MAX_SELECT  (MAX_SEL)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // place one record in the sorted cells; on last_item fill ranked_q and clear the set
    function automatic void rank_record(input tks_pkg::in_word_t w);
        int pos;
        int c;
        int n;
        tks_pkg::out_word_t r;
        ranked_q.delete();
        if (set_arrivals < MAX_REC)
        begin
            pos = 0;
            while (pos < held_count && !(held_height[pos] > w.height
                   || (held_height[pos] == w.height && held_name[pos] > w.name_key)))
                pos++;
            if (pos < MAX_SEL)
            begin
                c = (held_count < MAX_SEL) ? held_count : MAX_SEL - 1;
                while (c > pos)
                begin
                    held_height[c] = held_height[c-1];
                    held_name[c]   = held_name[c-1];
                    held_index[c]  = held_index[c-1];
                    c--;
                end
                held_height[pos] = w.height;
                held_name[pos]   = w.name_key;
                held_index[pos]  = tks_pkg::INDEX_W'(set_arrivals);
                if (held_count < MAX_SEL)
                    held_count++;
            end
            set_arrivals++;
        end
        if (w.last_item)
        begin
            n = (sel_count > MAX_SEL) ? MAX_SEL : int'(sel_count);
            if (n > held_count)
                n = held_count;
            for (int k = 0; k < n; k++)
            begin
                r.out_height    = held_height[k];
                r.out_name_key  = held_name[k];
                r.arrival_index = held_index[k];
                r.last_result   = (k == n - 1);
                ranked_q.push_back(r);
            end
            held_count   = 0;
            set_arrivals = 0;
        end
    endfunction

    function automatic tks_pkg::in_word_t random_record(input bit last);
        tks_pkg::in_word_t w;
        case ($urandom_range(0, 5))
            0:       w.height = '0;
            1:       w.height = '1;
            2, 3:    w.height = tks_pkg::HEIGHT_W'($urandom_range(100, 103));
            default: w.height = tks_pkg::HEIGHT_W'($urandom);
        endcase
        case ($urandom_range(0, 6))
            0:       w.name_key = '0;
            1:       w.name_key = '1;
            2:       w.name_key = NAME_ALICE;
            3:       w.name_key = NAME_BOB;
            default: w.name_key = {$urandom, $urandom};
        endcase
        w.last_item = last;
        return w;
    endfunction

    function automatic void flag_mismatch(input string what, input tks_pkg::out_word_t want,
                                          input tks_pkg::out_word_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t %s: want h/key/idx/last %0d/%h/%0d/%0b, got %0d/%h/%0d/%0b",
                     $time, what, want.out_height, want.out_name_key, want.arrival_index,
                     want.last_result, got.out_height, got.out_name_key, got.arrival_index,
                     got.last_result);
    endfunction

    // hold the word until the edge that takes it; valid stays high for a following word
    task automatic send_record(input tks_pkg::in_word_t w);
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic offer_record(input tks_pkg::in_word_t w);
        send_record(w);
        rank_record(w);
        foreach (ranked_q[i])
            owed_records.push_back(ranked_q[i]);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (owed_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_top_count(input logic [tks_pkg::CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sel_count  = value;
    endtask

    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_records.size() == 0)
                flag_mismatch("result with nothing owed", '0, out_data);
            else
            begin
                head_rank = owed_records.pop_front();
                if (out_data.out_height !== head_rank.out_height
                    || out_data.out_name_key !== head_rank.out_name_key
                    || out_data.arrival_index !== head_rank.arrival_index
                    || out_data.last_result !== head_rank.last_result)
                    flag_mismatch("result mismatch", head_rank, out_data);
            end
        end
    end

    initial
    begin
        phase_t ph;
        int     left;
        int     len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_rows[r])
        begin
            send_record(probe_rows[r].word);
            rank_record(probe_rows[r].word);
            if (probe_rows[r].typed)
                owed_records.push_back(probe_rows[r].want);
            else
                foreach (ranked_q[i])
                    owed_records.push_back(ranked_q[i]);
        end
        drain_results();

        phase_plan[5].top = tks_pkg::CFG_W'($urandom_range(1, MAX_SEL));
        foreach (phase_plan[p])
        begin
            ph = phase_plan[p];
            set_top_count(ph.top);
            gap_pct   = ph.gap_pct;
            stall_pct = ph.stall_pct;
            left      = ph.budget;
            while (left > 0)
            begin
                // flood set runs past capacity so its last_item lands on a dropped record
                if (ph.flood)
                    len = left;
                else if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(MAX_SEL + 1, 40);
                else
                    len = $urandom_range(1, MAX_SEL);
                if (len > left)
                    len = left;
                for (int i = 0; i < len; i++)
                    offer_record(random_record(i == len - 1));
                left -= len;
                if ($urandom_range(0, 5) == 0)
                    drain_results();
            end
            drain_results();
        end

        if (mismatch_count == 0 && owed_records.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
design/tks_pkg.sv
design/tks_cell.sv
design/top_k_smallest_select_unit.sv
tb/top_k_smallest_select_unit_tb.sv
